### design/tcsm_pkg.sv
// ----------------------------------------------------------------------------
// Three-channel serial mux package
// Shared constants for the receivers, the tick queue and the scheduler.
// ----------------------------------------------------------------------------
package tcsm_pkg;

    localparam int RingDepthDefault = 128;
    localparam int ChannelsDefault  = 3;
    localparam int QueueDepth       = 4;

    localparam logic [7:0] IdleMark     = 8'hff;
    localparam logic [7:0] FirstBitTick = 8'd6;
    localparam logic [7:0] LastBitTick  = 8'd34;
    localparam logic [7:0] StopTick     = 8'd38;
    localparam logic [7:0] WaitReset    = 8'd200;

endpackage

### design/tcsm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/tcsm_front.sv
// ----------------------------------------------------------------------------
// Serial receivers
// One oversampling receiver per channel; emits the bytes framed this tick.
// ----------------------------------------------------------------------------
module tcsm_front #(
    parameter int CHANNELS = tcsm_pkg::ChannelsDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick,
    input  logic [2:0]            i_levels,
    output logic [CHANNELS-1:0]   o_push,
    output logic [CHANNELS*8-1:0] o_bytes
);

    logic [7:0] r_count [CHANNELS];
    logic [7:0] n_count [CHANNELS];
    logic [7:0] r_shift [CHANNELS];
    logic [7:0] n_shift [CHANNELS];

    always_comb begin
        logic       lvl;
        logic [7:0] t;
        for (int c = 0; c < CHANNELS; c++) begin
            lvl        = (c < 3) ? i_levels[c] : 1'b1;
            t          = r_count[c] + 8'd1;
            n_count[c] = r_count[c];
            n_shift[c] = r_shift[c];
            o_push[c]  = 1'b0;
            o_bytes[c*8 +: 8] = r_shift[c];
            if (r_count[c] == tcsm_pkg::IdleMark) begin
                if (!lvl) begin
                    n_count[c] = 8'd0;
                end
            end else begin
                n_count[c] = t;
                if (t >= tcsm_pkg::FirstBitTick && t <= tcsm_pkg::LastBitTick
                        && (t[1:0] == tcsm_pkg::FirstBitTick[1:0])) begin
                    n_shift[c] = {lvl, r_shift[c][7:1]};
                end else if (t == tcsm_pkg::StopTick) begin
                    o_push[c]  = lvl & i_tick;
                    n_count[c] = tcsm_pkg::IdleMark;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (!i_rst_n) begin
                r_count[c] <= tcsm_pkg::IdleMark;
                r_shift[c] <= 8'd0;
            end else if (i_tick) begin
                r_count[c] <= n_count[c];
                r_shift[c] <= n_shift[c];
            end
        end
    end

endmodule

### design/tcsm_queue.sv
// ----------------------------------------------------------------------------
// Tick queue
// Short FIFO of per-tick records between the receivers and the scheduler.
// ----------------------------------------------------------------------------
module tcsm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_nonempty,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(tcsm_pkg::QueueDepth);

    logic [WIDTH-1:0] r_slot [tcsm_pkg::QueueDepth];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [AW:0]      r_count;

    assign o_full     = (r_count == (AW+1)'(tcsm_pkg::QueueDepth));
    assign o_nonempty = (r_count != '0);
    assign o_data     = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

endmodule

### design/tcsm_back.sv
// ----------------------------------------------------------------------------
// Ring buffers and round-robin scheduler
// Stores received bytes per channel and hands at most one byte per tick onward.
// ----------------------------------------------------------------------------
module tcsm_back #(
    parameter int RING_DEPTH = tcsm_pkg::RingDepthDefault,
    parameter int CHANNELS   = tcsm_pkg::ChannelsDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_wait_ticks,
    input  logic                  i_rec_valid,
    input  logic [CHANNELS-1:0]   i_push,
    input  logic [CHANNELS*8-1:0] i_bytes,
    input  logic                  i_tx_ready,
    output logic                  o_rec_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_tx_valid,
    output logic [7:0]            o_tx_byte,
    output logic [1:0]            o_served_channel
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [AW-1:0] r_head [CHANNELS];
    logic [AW-1:0] r_tail [CHANNELS];
    logic [AW-1:0] n_head [CHANNELS];
    logic [AW-1:0] nh     [CHANNELS];
    logic [CHANNELS-1:0] w_we;
    logic [CHANNELS-1:0] w_re;
    logic [7:0]    w_rdata [CHANNELS];
    logic [CW-1:0] r_cur;
    logic [CW-1:0] n_cur;
    logic          r_busy;
    logic          n_busy;
    logic [7:0]    r_cnt;
    logic [7:0]    n_cnt;
    logic [7:0]    w_dec;
    logic          w_fire;
    logic          w_run;
    logic          w_empty;
    logic          w_pop;
    logic          w_bypass;
    logic [AW-1:0] w_tail;
    logic [AW-1:0] w_tail_next;
    logic          r_valid;
    logic          r_txv;
    logic          r_bypass;
    logic [7:0]    r_bbyte;
    logic [CW-1:0] r_served;

    assign w_fire    = i_rec_valid && (!r_valid || !i_stall);
    assign o_rec_pop = w_fire;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            nh[c]     = (r_head[c] == AW'(RING_DEPTH - 1)) ? '0 : r_head[c] + AW'(1);
            w_we[c]   = w_fire && i_push[c] && (nh[c] != r_tail[c]);
            n_head[c] = w_we[c] ? nh[c] : r_head[c];
        end
        w_tail      = r_tail[r_cur];
        w_tail_next = (w_tail == AW'(RING_DEPTH - 1)) ? '0 : w_tail + AW'(1);
        w_run       = w_fire && (!r_busy || i_tx_ready);
        w_empty     = (w_tail == n_head[r_cur]);
        w_pop       = w_run && !w_empty;
        w_bypass    = (w_tail == r_head[r_cur]);
        w_dec       = r_cnt - 8'd1;
        n_busy      = r_busy;
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        for (int c = 0; c < CHANNELS; c++) begin
            w_re[c] = w_pop && !w_bypass && (r_cur == CW'(c));
        end
        if (w_run) begin
            if (w_empty) begin
                n_busy = 1'b0;
                n_cnt  = w_dec;
                if (w_dec == 8'd0) begin
                    n_cnt = i_wait_ticks;
                    n_cur = (r_cur == CW'(CHANNELS - 1)) ? '0 : r_cur + CW'(1);
                end
            end else begin
                n_busy = 1'b1;
                n_cnt  = i_wait_ticks;
            end
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_ring
        tcsm_ram #(
            .WIDTH(8),
            .DEPTH(RING_DEPTH)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_we[g]),
            .i_waddr(r_head[g]),
            .i_wdata(i_bytes[g*8 +: 8]),
            .i_re   (w_re[g]),
            .i_raddr(r_tail[g]),
            .o_rdata(w_rdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_bypass <= w_bypass;
            r_bbyte  <= i_bytes[r_cur*8 +: 8];
            r_served <= r_cur;
            r_txv    <= w_pop;
        end
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
            end
            r_cur   <= '0;
            r_busy  <= 1'b0;
            r_cnt   <= tcsm_pkg::WaitReset;
            r_valid <= 1'b0;
        end else begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_head[c] <= n_head[c];
                if (w_pop && r_cur == CW'(c)) begin
                    r_tail[c] <= w_tail_next;
                end
            end
            r_cur  <= n_cur;
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            if (w_fire) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_tx_valid       = r_txv;
    assign o_tx_byte        = !r_txv ? 8'd0 : (r_bypass ? r_bbyte : w_rdata[r_served]);
    assign o_served_channel = 2'(r_served);

endmodule

### design/three_channel_serial_mux_top.sv
// A tick's record passes through the tick queue and then the scheduler's
// output registers before its result appears. Throughput: one tick per cycle
// while the four-entry tick queue is not full; the queue feeds the scheduler.
// Reset: synchronous active-low reset idles all receivers, empties all rings,
// selects channel 0 and loads the wait count with 200. No clearing pass.
// ----------------------------------------------------------------------------
// Three-channel serial mux top level
// Serial receivers feeding per-channel rings and a round-robin scheduler.
// ----------------------------------------------------------------------------
module three_channel_serial_mux_top #(
    parameter int RING_DEPTH = tcsm_pkg::RingDepthDefault,
    parameter int CHANNELS   = tcsm_pkg::ChannelsDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_line_zero,
    input  logic       i_line_one,
    input  logic       i_line_two,
    input  logic       i_tx_ready,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic [1:0] o_served_channel,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_wait_ticks
);

    localparam int RW = CHANNELS * 9 + 1;

    logic                  w_tick;
    logic [CHANNELS-1:0]   w_push;
    logic [CHANNELS*8-1:0] w_bytes;
    logic                  w_full;
    logic                  w_q_valid;
    logic                  w_q_pop;
    logic [RW-1:0]         w_q_data;
    logic [7:0]            r_wait_ticks;

    assign o_stall     = w_full;
    assign w_tick      = i_valid && !w_full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= tcsm_pkg::WaitReset;
        end else if (i_cfg_valid) begin
            r_wait_ticks <= i_cfg_wait_ticks;
        end
    end

    tcsm_front #(
        .CHANNELS(CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (w_tick),
        .i_levels({i_line_two, i_line_one, i_line_zero}),
        .o_push  (w_push),
        .o_bytes (w_bytes)
    );

    tcsm_queue #(
        .WIDTH(RW)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_tick),
        .i_data    ({i_tx_ready, w_push, w_bytes}),
        .i_pop     (w_q_pop),
        .o_full    (w_full),
        .o_nonempty(w_q_valid),
        .o_data    (w_q_data)
    );

    tcsm_back #(
        .RING_DEPTH(RING_DEPTH),
        .CHANNELS  (CHANNELS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wait_ticks    (r_wait_ticks),
        .i_rec_valid     (w_q_valid),
        .i_push          (w_q_data[CHANNELS*8 +: CHANNELS]),
        .i_bytes         (w_q_data[CHANNELS*8-1:0]),
        .i_tx_ready      (w_q_data[RW-1]),
        .o_rec_pop       (w_q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_tx_valid      (o_tx_valid),
        .o_tx_byte       (o_tx_byte),
        .o_served_channel(o_served_channel)
    );

endmodule

### design/tcsm_checker.sv
// ----------------------------------------------------------------------------
// Three-channel serial mux checker
// Port-level checks on the result channel of the top level.
// ----------------------------------------------------------------------------
module tcsm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_byte,
    input logic [1:0] o_served_channel
);

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tx_valid) |-> (o_tx_byte == 8'd0))
        else $error("Byte is not zero on a transaction without data.");

    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_served_channel != 2'd3))
        else $error("Served channel is out of range.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_tx_valid)
            && $stable(o_tx_byte) && $stable(o_served_channel)))
        else $error("Stalled transaction changed.");

endmodule

bind three_channel_serial_mux_top tcsm_checker u_tcsm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_tx_valid      (o_tx_valid),
    .o_tx_byte       (o_tx_byte),
    .o_served_channel(o_served_channel)
);

### verif/three_channel_serial_mux_top_tb.sv
// ----------------------------------------------------------------------------
// Three-channel serial mux testbench
// Drives oversampling ticks carrying serial frames on three lines, predicts
// every scheduler output per tick and compares each output transaction with
// the oldest prediction under random idling on both channels.
// ----------------------------------------------------------------------------
module three_channel_serial_mux_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = 128;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] served;
    } sched_out_t;

    typedef struct packed {
        logic [2:0] lines;
        logic       tx_ready;
        logic       check_fixed;
        sched_out_t fixed_out;
    } tick_row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_line_zero = 1'b1;
    logic       i_line_one = 1'b1;
    logic       i_line_two = 1'b1;
    logic       i_tx_ready = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic [1:0] o_served_channel;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_wait_ticks = 8'd0;

    three_channel_serial_mux_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_line_zero(i_line_zero), .i_line_one(i_line_one),
        .i_line_two(i_line_two), .i_tx_ready(i_tx_ready),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_tx_valid(o_tx_valid), .o_tx_byte(o_tx_byte),
        .o_served_channel(o_served_channel),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_wait_ticks(i_cfg_wait_ticks)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("three_channel_serial_mux_top_tb NOT OK");
        $finish;
    end

    // Predictor state.
    logic [7:0] p_wait;
    logic [7:0] p_tick [3];
    logic [7:0] p_shift [3];
    logic [7:0] p_ring [3][Depth];
    logic [6:0] p_head [3];
    logic [6:0] p_tail [3];
    logic [1:0] p_chan;
    logic       p_busy;
    logic [7:0] p_count;

    sched_out_t expected_outs[$];
    int         errors = 0;
    int         send_idle = 0;
    int         recv_idle = 0;

    function automatic void predictor_reset();
        p_wait = tcsm_pkg::WaitReset;
        for (int c = 0; c < 3; c++) begin
            p_tick[c] = tcsm_pkg::IdleMark;
            p_shift[c] = 8'd0;
            p_head[c] = 7'd0;
            p_tail[c] = 7'd0;
        end
        p_chan = 2'd0;
        p_busy = 1'b0;
        p_count = tcsm_pkg::WaitReset;
    endfunction

    function automatic sched_out_t predict_tick(logic [2:0] lines, logic rdy);
        sched_out_t r;
        logic [7:0] t;
        r = '0;
        for (int c = 0; c < 3; c++) begin
            t = p_tick[c];
            if (t == tcsm_pkg::IdleMark) begin
                if (!lines[c]) p_tick[c] = 8'd0;
            end else begin
                t = t + 8'd1;
                p_tick[c] = t;
                if (t >= tcsm_pkg::FirstBitTick && t <= tcsm_pkg::LastBitTick
                        && t[1:0] == 2'd2) begin
                    p_shift[c] = {lines[c], p_shift[c][7:1]};
                end else if (t == tcsm_pkg::StopTick) begin
                    if (lines[c] && (p_head[c] + 7'd1) != p_tail[c]) begin
                        p_ring[c][p_head[c]] = p_shift[c];
                        p_head[c] = p_head[c] + 7'd1;
                    end
                    p_tick[c] = tcsm_pkg::IdleMark;
                end
            end
        end
        r.served = p_chan;
        if (!p_busy || rdy) begin
            if (p_tail[p_chan] == p_head[p_chan]) begin
                p_busy = 1'b0;
                p_count = p_count - 8'd1;
                if (p_count == 8'd0) begin
                    p_count = p_wait;
                    p_chan = (p_chan == 2'd2) ? 2'd0 : p_chan + 2'd1;
                end
            end else begin
                r.tx_byte = p_ring[p_chan][p_tail[p_chan]];
                r.tx_valid = 1'b1;
                p_tail[p_chan] = p_tail[p_chan] + 7'd1;
                p_busy = 1'b1;
                p_count = p_wait;
            end
        end
        return r;
    endfunction

    task automatic send_tick(logic [2:0] lines, logic rdy);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_line_zero <= lines[0];
        i_line_one <= lines[1];
        i_line_two <= lines[2];
        i_tx_ready <= rdy;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_outs.push_back(predict_tick(lines, rdy));
    endtask

    // Sends one frame per line in parallel; a line with send clear stays high.
    task automatic send_frames(logic [2:0] send, logic [7:0] b0, logic [7:0] b1,
                               logic [7:0] b2, logic [2:0] stop_ok, int rdy_pct);
        logic [2:0] lv;
        logic [7:0] bytes [3];
        int k;
        bytes[0] = b0; bytes[1] = b1; bytes[2] = b2;
        for (int t = 0; t < 40; t++) begin
            for (int c = 0; c < 3; c++) begin
                if (!send[c]) lv[c] = 1'b1;
                else if (t < 4) lv[c] = 1'b0;
                else if (t < 36) begin
                    k = (t - 4) / 4;
                    lv[c] = bytes[c][k];
                end else lv[c] = stop_ok[c];
            end
            send_tick(lv, $urandom_range(99) < rdy_pct);
        end
    endtask

    task automatic drain_and_write(logic [7:0] val);
        i_valid <= 1'b0;
        while (expected_outs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_wait_ticks <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        p_wait = val;
    endtask

    always @(posedge i_clk) begin
        sched_out_t got;
        sched_out_t exp;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_tx_valid, o_tx_byte, o_served_channel};
            if (expected_outs.size() == 0) begin
                $display("%0t: unexpected transaction %h", $time, got);
                errors++;
            end else begin
                exp = expected_outs.pop_front();
                if (got.tx_valid !== exp.tx_valid) begin
                    $display("%0t: tx_valid exp %b got %b", $time, exp.tx_valid, got.tx_valid);
                    errors++;
                end
                if (got.tx_byte !== exp.tx_byte) begin
                    $display("%0t: tx_byte exp %h got %h", $time, exp.tx_byte, got.tx_byte);
                    errors++;
                end
                if (got.served !== exp.served) begin
                    $display("%0t: served exp %0d got %0d", $time, exp.served, got.served);
                    errors++;
                end
            end
        end
        if (recv_idle > 0) i_stall <= ($urandom_range(99) < recv_idle);
        else i_stall <= 1'b0;
    end

    tick_row_t rows[$];

    initial begin
        sched_out_t exp;
        sched_out_t fix;
        int n;
        predictor_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed ticks: idle after reset, start bits on all lines, then line one high.
        rows.push_back('{3'b111, 1'b0, 1'b1, '{1'b0, 8'd0, 2'd0}});
        rows.push_back('{3'b111, 1'b1, 1'b1, '{1'b0, 8'd0, 2'd0}});
        rows.push_back('{3'b000, 1'b0, 1'b0, '0});
        rows.push_back('{3'b010, 1'b1, 1'b0, '0});
        foreach (rows[i]) begin
            fix = rows[i].fixed_out;
            send_tick(rows[i].lines, rows[i].tx_ready);
            if (rows[i].check_fixed) begin
                exp = expected_outs[expected_outs.size() - 1];
                if (exp !== fix) begin
                    $display("%0t: table row %0d exp %h predicted %h", $time, i, fix, exp);
                    errors++;
                end
            end
        end
        for (int t = 0; t < 40; t++) send_tick(3'b111, 1'b1);
        drain_and_write(8'd1);
        send_frames(3'b111, 8'h00, 8'hff, 8'ha5, 3'b111, 100);
        send_frames(3'b111, 8'hff, 8'h00, 8'h5a, 3'b010, 0);
        for (int t = 0; t < 20; t++) send_tick(3'b111, 1'b1);

        // Random phases across idling modes and wait settings.
        for (int ph = 0; ph < 3; ph++) begin
            drain_and_write(ph == 0 ? 8'd0 : (ph == 1 ? 8'd255 : 8'd3));
            if (ph == 2) drain_and_write(8'($urandom_range(1, 20)));
            send_idle = (ph == 0) ? 33 : (ph == 1 ? 50 : 0);
            recv_idle = (ph == 0) ? 50 : (ph == 1 ? 33 : 0);
            n = 0;
            while (n < 250) begin
                if ($urandom_range(9) < 7) begin
                    send_frames(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                ($urandom_range(9) == 0) ? 3'($urandom) : 3'b111,
                                $urandom_range(100));
                    n += 40;
                end else begin
                    send_tick(3'($urandom), 1'($urandom));
                    n++;
                end
            end
        end

        send_idle = 0;
        recv_idle = 0;
        i_valid <= 1'b0;
        fork
            while (expected_outs.size() != 0) @(posedge i_clk);
            begin
                repeat (20000) @(posedge i_clk);
            end
        join_any
        disable fork;
        repeat (10) @(posedge i_clk);
        if (errors == 0 && expected_outs.size() == 0) begin
            $display("three_channel_serial_mux_top_tb OK");
        end else begin
            $display("three_channel_serial_mux_top_tb NOT OK");
        end
        $finish;
    end
endmodule
